FILE: src/dllc_pkg.sv
package dllc_pkg;

    localparam int POOL_NODES = 64;
    localparam int PTR_W      = $clog2(POOL_NODES + 1);
    localparam int ADDR_W     = $clog2(POOL_NODES);
    localparam int DATA_W     = 32;
    localparam int OP_W       = 4;
    localparam logic [PTR_W-1:0] NIL = PTR_W'(POOL_NODES);

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR      = 4'd0,
        OP_INS_FIRST  = 4'd1,
        OP_INS_LAST   = 4'd2,
        OP_CUR_FIRST  = 4'd3,
        OP_CUR_LAST   = 4'd4,
        OP_DEL_FIRST  = 4'd5,
        OP_DEL_LAST   = 4'd6,
        OP_DEL_AFTER  = 4'd7,
        OP_DEL_BEFORE = 4'd8,
        OP_INS_AFTER  = 4'd9,
        OP_INS_BEFORE = 4'd10,
        OP_WRITE      = 4'd11,
        OP_NEXT       = 4'd12,
        OP_PREV       = 4'd13,
        OP_QUERY      = 4'd14
    } t_op;

    // pointer sources for addresses, link data and pointer loads
    typedef enum logic [3:0] {
        P_NIL, P_HEAD, P_TAIL, P_CUR, P_N, P_T, P_U, P_FREE, P_RDN, P_RDP, P_BUMP
    } t_psel;

    typedef enum logic [4:0] {
        S_IDLE, S_DEC, S_ALLOC, S_ALLOC2, S_LINK, S_LINK2, S_LINK3,
        S_DEL_HEAD, S_DEL_TAIL, S_DEL_NX_A, S_DEL_NX_B, S_DEL_PV_A, S_DEL_PV_B,
        S_GIVE, S_STEP, S_RD_HEAD, S_RD_TAIL, S_RD_CUR, S_FIN
    } t_state;

    typedef struct packed {
        logic  ld_in;
        logic  clear;
        logic  rd_en;
        t_psel rd_addr;
        logic  nx_we;
        t_psel nx_addr;
        t_psel nx_data;
        logic  pv_we;
        t_psel pv_addr;
        t_psel pv_data;
        logic  dt_we;
        t_psel dt_addr;
        logic  ld_head;
        t_psel head_src;
        logic  ld_tail;
        t_psel tail_src;
        logic  ld_cur;
        t_psel cur_src;
        logic  ld_free;
        t_psel free_src;
        logic  ld_n;
        t_psel n_src;
        logic  ld_t;
        t_psel t_src;
        logic  ld_u;
        t_psel u_src;
        logic  bump_inc;
        logic  err_set;
        logic  cap_first;
        logic  cap_last;
        logic  out_ld;
    } t_cmd;

    typedef struct packed {
        logic head_nil;
        logic tail_nil;
        logic cur_nil;
        logic free_nil;
        logic bump_full;
        logic cur_is_head;
        logic cur_is_tail;
        logic cur_is_n;
        logic rdn_nil;
        logic rdp_nil;
        logic u_nil;
    } t_stat;

endpackage

FILE: src/dllc_cmd_if.sv
interface dllc_cmd_if;
    logic                                 valid;
    logic                                 ready;
    logic [dllc_pkg::OP_W-1:0]            op;
    logic signed [dllc_pkg::DATA_W-1:0]   value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

FILE: src/dllc_res_if.sv
interface dllc_res_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 status;
    logic signed [dllc_pkg::DATA_W-1:0]   first_value;
    logic                                 first_valid;
    logic signed [dllc_pkg::DATA_W-1:0]   last_value;
    logic                                 last_valid;
    logic signed [dllc_pkg::DATA_W-1:0]   active_value;
    logic                                 active_valid;

    modport source (output valid, output status, output first_value, output first_valid,
                    output last_value, output last_valid, output active_value,
                    output active_valid, input ready);
    modport sink   (input valid, input status, input first_value, input first_valid,
                    input last_value, input last_valid, input active_value,
                    input active_valid, output ready);
endinterface

FILE: src/dllc_ram.sv
module dllc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: src/dllc_ctrl.sv
module dllc_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [dllc_pkg::OP_W-1:0] i_op,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output dllc_pkg::t_cmd            o_cmd,
    input  dllc_pkg::t_stat           i_stat
);
    dllc_pkg::t_state r_state, n_state;
    dllc_pkg::t_op    r_op, n_op;
    logic             r_out_valid, n_out_valid;
    dllc_pkg::t_cmd   c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dllc_pkg::S_IDLE;
            r_op        <= dllc_pkg::OP_QUERY;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        c          = '0;
        n_state    = r_state;
        n_op       = r_op;
        o_in_ready = 1'b0;
        unique case (r_state)
            dllc_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    c.ld_in = 1'b1;
                    n_op    = dllc_pkg::t_op'(i_op);
                    n_state = dllc_pkg::S_DEC;
                end
            end
            dllc_pkg::S_DEC: begin
                n_state = dllc_pkg::S_RD_HEAD;
                unique case (r_op)
                    dllc_pkg::OP_CLEAR: c.clear = 1'b1;
                    dllc_pkg::OP_INS_FIRST, dllc_pkg::OP_INS_LAST:
                        n_state = dllc_pkg::S_ALLOC;
                    dllc_pkg::OP_CUR_FIRST: begin
                        c.ld_cur = 1'b1; c.cur_src = dllc_pkg::P_HEAD;
                    end
                    dllc_pkg::OP_CUR_LAST: begin
                        c.ld_cur = 1'b1; c.cur_src = dllc_pkg::P_TAIL;
                    end
                    dllc_pkg::OP_DEL_FIRST: begin
                        if (!i_stat.head_nil) begin
                            c.rd_en = 1'b1; c.rd_addr = dllc_pkg::P_HEAD;
                            c.ld_n  = 1'b1; c.n_src   = dllc_pkg::P_HEAD;
                            n_state = dllc_pkg::S_DEL_HEAD;
                        end
                    end
                    dllc_pkg::OP_DEL_LAST: begin
                        if (!i_stat.tail_nil) begin
                            c.rd_en = 1'b1; c.rd_addr = dllc_pkg::P_TAIL;
                            c.ld_n  = 1'b1; c.n_src   = dllc_pkg::P_TAIL;
                            n_state = dllc_pkg::S_DEL_TAIL;
                        end
                    end
                    dllc_pkg::OP_DEL_AFTER: begin
                        if (!i_stat.cur_nil && !i_stat.cur_is_tail) begin
                            c.rd_en = 1'b1; c.rd_addr = dllc_pkg::P_CUR;
                            n_state = dllc_pkg::S_DEL_NX_A;
                        end
                    end
                    dllc_pkg::OP_DEL_BEFORE: begin
                        if (!i_stat.cur_nil && !i_stat.cur_is_head) begin
                            c.rd_en = 1'b1; c.rd_addr = dllc_pkg::P_CUR;
                            n_state = dllc_pkg::S_DEL_PV_A;
                        end
                    end
                    dllc_pkg::OP_INS_AFTER, dllc_pkg::OP_INS_BEFORE: begin
                        if (!i_stat.cur_nil) n_state = dllc_pkg::S_ALLOC;
                    end
                    dllc_pkg::OP_WRITE: begin
                        if (!i_stat.cur_nil) begin
                            c.dt_we = 1'b1; c.dt_addr = dllc_pkg::P_CUR;
                        end
                    end
                    dllc_pkg::OP_NEXT: begin
                        if (!i_stat.cur_nil) begin
                            if (i_stat.cur_is_tail) begin
                                c.ld_cur = 1'b1; c.cur_src = dllc_pkg::P_NIL;
                            end else begin
                                c.rd_en = 1'b1; c.rd_addr = dllc_pkg::P_CUR;
                                n_state = dllc_pkg::S_STEP;
                            end
                        end
                    end
                    dllc_pkg::OP_PREV: begin
                        if (!i_stat.cur_nil) begin
                            if (i_stat.cur_is_head) begin
                                c.ld_cur = 1'b1; c.cur_src = dllc_pkg::P_NIL;
                            end else begin
                                c.rd_en = 1'b1; c.rd_addr = dllc_pkg::P_CUR;
                                n_state = dllc_pkg::S_STEP;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            dllc_pkg::S_ALLOC: begin
                // free stack first, then the bump counter
                if (!i_stat.free_nil) begin
                    c.ld_n  = 1'b1; c.n_src   = dllc_pkg::P_FREE;
                    c.rd_en = 1'b1; c.rd_addr = dllc_pkg::P_FREE;
                    n_state = dllc_pkg::S_ALLOC2;
                end else if (!i_stat.bump_full) begin
                    c.ld_n     = 1'b1; c.n_src = dllc_pkg::P_BUMP;
                    c.bump_inc = 1'b1;
                    n_state    = dllc_pkg::S_LINK;
                end else begin
                    c.err_set = 1'b1;
                    n_state   = dllc_pkg::S_RD_HEAD;
                end
            end
            dllc_pkg::S_ALLOC2: begin
                c.ld_free = 1'b1; c.free_src = dllc_pkg::P_RDN;
                n_state   = dllc_pkg::S_LINK;
            end
            dllc_pkg::S_LINK: begin
                c.dt_we = 1'b1; c.dt_addr = dllc_pkg::P_N;
                n_state = dllc_pkg::S_LINK2;
                unique case (r_op)
                    dllc_pkg::OP_INS_FIRST: begin
                        c.nx_we = 1'b1; c.nx_addr = dllc_pkg::P_N; c.nx_data = dllc_pkg::P_HEAD;
                        c.pv_we = 1'b1; c.pv_addr = dllc_pkg::P_N; c.pv_data = dllc_pkg::P_NIL;
                        if (i_stat.head_nil) begin
                            c.ld_head = 1'b1; c.head_src = dllc_pkg::P_N;
                            c.ld_tail = 1'b1; c.tail_src = dllc_pkg::P_N;
                            n_state   = dllc_pkg::S_RD_HEAD;
                        end
                    end
                    dllc_pkg::OP_INS_LAST: begin
                        c.nx_we = 1'b1; c.nx_addr = dllc_pkg::P_N; c.nx_data = dllc_pkg::P_NIL;
                        c.pv_we = 1'b1; c.pv_addr = dllc_pkg::P_N; c.pv_data = dllc_pkg::P_TAIL;
                        if (i_stat.tail_nil) begin
                            c.ld_head = 1'b1; c.head_src = dllc_pkg::P_N;
                            c.ld_tail = 1'b1; c.tail_src = dllc_pkg::P_N;
                            n_state   = dllc_pkg::S_RD_HEAD;
                        end
                    end
                    dllc_pkg::OP_INS_AFTER: begin
                        c.pv_we = 1'b1; c.pv_addr = dllc_pkg::P_N; c.pv_data = dllc_pkg::P_CUR;
                        c.rd_en = 1'b1; c.rd_addr = dllc_pkg::P_CUR;
                    end
                    dllc_pkg::OP_INS_BEFORE: begin
                        c.nx_we = 1'b1; c.nx_addr = dllc_pkg::P_N; c.nx_data = dllc_pkg::P_CUR;
                        c.rd_en = 1'b1; c.rd_addr = dllc_pkg::P_CUR;
                    end
                    default: n_state = dllc_pkg::S_RD_HEAD;
                endcase
            end
            dllc_pkg::S_LINK2: begin
                n_state = dllc_pkg::S_RD_HEAD;
                unique case (r_op)
                    dllc_pkg::OP_INS_FIRST: begin
                        c.pv_we = 1'b1; c.pv_addr = dllc_pkg::P_HEAD; c.pv_data = dllc_pkg::P_N;
                        c.ld_head = 1'b1; c.head_src = dllc_pkg::P_N;
                    end
                    dllc_pkg::OP_INS_LAST: begin
                        c.nx_we = 1'b1; c.nx_addr = dllc_pkg::P_TAIL; c.nx_data = dllc_pkg::P_N;
                        c.ld_tail = 1'b1; c.tail_src = dllc_pkg::P_N;
                    end
                    dllc_pkg::OP_INS_AFTER: begin
                        c.nx_we = 1'b1; c.nx_addr = dllc_pkg::P_N; c.nx_data = dllc_pkg::P_RDN;
                        c.ld_u  = 1'b1; c.u_src   = dllc_pkg::P_RDN;
                        n_state = dllc_pkg::S_LINK3;
                    end
                    dllc_pkg::OP_INS_BEFORE: begin
                        c.pv_we = 1'b1; c.pv_addr = dllc_pkg::P_N; c.pv_data = dllc_pkg::P_RDP;
                        c.ld_u  = 1'b1; c.u_src   = dllc_pkg::P_RDP;
                        n_state = dllc_pkg::S_LINK3;
                    end
                    default: ;
                endcase
            end
            dllc_pkg::S_LINK3: begin
                n_state = dllc_pkg::S_RD_HEAD;
                if (r_op == dllc_pkg::OP_INS_AFTER) begin
                    c.nx_we = 1'b1; c.nx_addr = dllc_pkg::P_CUR; c.nx_data = dllc_pkg::P_N;
                    if (i_stat.u_nil) begin
                        c.ld_tail = 1'b1; c.tail_src = dllc_pkg::P_N;
                    end else begin
                        c.pv_we = 1'b1; c.pv_addr = dllc_pkg::P_U; c.pv_data = dllc_pkg::P_N;
                    end
                end else begin
                    c.pv_we = 1'b1; c.pv_addr = dllc_pkg::P_CUR; c.pv_data = dllc_pkg::P_N;
                    if (i_stat.u_nil) begin
                        c.ld_head = 1'b1; c.head_src = dllc_pkg::P_N;
                    end else begin
                        c.nx_we = 1'b1; c.nx_addr = dllc_pkg::P_U; c.nx_data = dllc_pkg::P_N;
                    end
                end
            end
            dllc_pkg::S_DEL_HEAD: begin
                if (i_stat.cur_is_n) begin
                    c.ld_cur = 1'b1; c.cur_src = dllc_pkg::P_NIL;
                end
                c.ld_head = 1'b1; c.head_src = dllc_pkg::P_RDN;
                if (i_stat.rdn_nil) begin
                    c.ld_tail = 1'b1; c.tail_src = dllc_pkg::P_NIL;
                end else begin
                    c.pv_we = 1'b1; c.pv_addr = dllc_pkg::P_RDN; c.pv_data = dllc_pkg::P_NIL;
                end
                n_state = dllc_pkg::S_GIVE;
            end
            dllc_pkg::S_DEL_TAIL: begin
                if (i_stat.cur_is_n) begin
                    c.ld_cur = 1'b1; c.cur_src = dllc_pkg::P_NIL;
                end
                c.ld_tail = 1'b1; c.tail_src = dllc_pkg::P_RDP;
                if (i_stat.rdp_nil) begin
                    c.ld_head = 1'b1; c.head_src = dllc_pkg::P_NIL;
                end else begin
                    c.nx_we = 1'b1; c.nx_addr = dllc_pkg::P_RDP; c.nx_data = dllc_pkg::P_NIL;
                end
                n_state = dllc_pkg::S_GIVE;
            end
            dllc_pkg::S_DEL_NX_A: begin
                c.ld_t  = 1'b1; c.t_src   = dllc_pkg::P_RDN;
                c.rd_en = 1'b1; c.rd_addr = dllc_pkg::P_RDN;
                n_state = dllc_pkg::S_DEL_NX_B;
            end
            dllc_pkg::S_DEL_NX_B: begin
                c.nx_we = 1'b1; c.nx_addr = dllc_pkg::P_CUR; c.nx_data = dllc_pkg::P_RDN;
                if (i_stat.rdn_nil) begin
                    c.ld_tail = 1'b1; c.tail_src = dllc_pkg::P_CUR;
                end else begin
                    c.pv_we = 1'b1; c.pv_addr = dllc_pkg::P_RDN; c.pv_data = dllc_pkg::P_CUR;
                end
                c.ld_n  = 1'b1; c.n_src = dllc_pkg::P_T;
                n_state = dllc_pkg::S_GIVE;
            end
            dllc_pkg::S_DEL_PV_A: begin
                c.ld_t  = 1'b1; c.t_src   = dllc_pkg::P_RDP;
                c.rd_en = 1'b1; c.rd_addr = dllc_pkg::P_RDP;
                n_state = dllc_pkg::S_DEL_PV_B;
            end
            dllc_pkg::S_DEL_PV_B: begin
                c.pv_we = 1'b1; c.pv_addr = dllc_pkg::P_CUR; c.pv_data = dllc_pkg::P_RDP;
                if (i_stat.rdp_nil) begin
                    c.ld_head = 1'b1; c.head_src = dllc_pkg::P_CUR;
                end else begin
                    c.nx_we = 1'b1; c.nx_addr = dllc_pkg::P_RDP; c.nx_data = dllc_pkg::P_CUR;
                end
                c.ld_n  = 1'b1; c.n_src = dllc_pkg::P_T;
                n_state = dllc_pkg::S_GIVE;
            end
            dllc_pkg::S_GIVE: begin
                // push freed node on the free stack
                c.nx_we   = 1'b1; c.nx_addr = dllc_pkg::P_N; c.nx_data = dllc_pkg::P_FREE;
                c.ld_free = 1'b1; c.free_src = dllc_pkg::P_N;
                n_state   = dllc_pkg::S_RD_HEAD;
            end
            dllc_pkg::S_STEP: begin
                c.ld_cur  = 1'b1;
                c.cur_src = (r_op == dllc_pkg::OP_NEXT) ? dllc_pkg::P_RDN : dllc_pkg::P_RDP;
                n_state   = dllc_pkg::S_RD_HEAD;
            end
            dllc_pkg::S_RD_HEAD: begin
                c.rd_en = 1'b1; c.rd_addr = dllc_pkg::P_HEAD;
                n_state = dllc_pkg::S_RD_TAIL;
            end
            dllc_pkg::S_RD_TAIL: begin
                c.cap_first = 1'b1;
                c.rd_en = 1'b1; c.rd_addr = dllc_pkg::P_TAIL;
                n_state = dllc_pkg::S_RD_CUR;
            end
            dllc_pkg::S_RD_CUR: begin
                c.cap_last = 1'b1;
                c.rd_en = 1'b1; c.rd_addr = dllc_pkg::P_CUR;
                n_state = dllc_pkg::S_FIN;
            end
            dllc_pkg::S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    c.out_ld = 1'b1;
                    n_state  = dllc_pkg::S_IDLE;
                end
            end
            default: n_state = dllc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        if (c.out_ld) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_cmd       = c;
    assign o_out_valid = r_out_valid;
endmodule

FILE: src/dllc_dp.sv
module dllc_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  dllc_pkg::t_cmd                      i_cmd,
    output dllc_pkg::t_stat                     o_stat,
    input  logic signed [dllc_pkg::DATA_W-1:0]  i_value,
    output logic                                o_status,
    output logic signed [dllc_pkg::DATA_W-1:0]  o_first_value,
    output logic                                o_first_valid,
    output logic signed [dllc_pkg::DATA_W-1:0]  o_last_value,
    output logic                                o_last_valid,
    output logic signed [dllc_pkg::DATA_W-1:0]  o_active_value,
    output logic                                o_active_valid
);
    logic [dllc_pkg::PTR_W-1:0]  r_head, r_tail, r_cur, r_free, r_bump;
    logic [dllc_pkg::PTR_W-1:0]  r_n, r_t, r_u;
    logic [dllc_pkg::DATA_W-1:0] r_value;
    logic                        r_err;
    logic [dllc_pkg::DATA_W-1:0] r_fv, r_lv;
    logic [dllc_pkg::DATA_W-1:0] r_o_fv, r_o_lv, r_o_av;
    logic                        r_o_err, r_o_fvld, r_o_lvld, r_o_avld;

    logic [dllc_pkg::PTR_W-1:0]  rd_next, rd_prev;
    logic [dllc_pkg::DATA_W-1:0] rd_data;

    function automatic logic [dllc_pkg::PTR_W-1:0] pick(
        input dllc_pkg::t_psel s,
        input logic [dllc_pkg::PTR_W-1:0] head, tail, cur, n, t, u, free, rdn, rdp, bump
    );
        logic [dllc_pkg::PTR_W-1:0] p;
        unique case (s)
            dllc_pkg::P_NIL:  p = dllc_pkg::NIL;
            dllc_pkg::P_HEAD: p = head;
            dllc_pkg::P_TAIL: p = tail;
            dllc_pkg::P_CUR:  p = cur;
            dllc_pkg::P_N:    p = n;
            dllc_pkg::P_T:    p = t;
            dllc_pkg::P_U:    p = u;
            dllc_pkg::P_FREE: p = free;
            dllc_pkg::P_RDN:  p = rdn;
            dllc_pkg::P_RDP:  p = rdp;
            dllc_pkg::P_BUMP: p = bump;
            default:          p = dllc_pkg::NIL;
        endcase
        return p;
    endfunction

    logic [dllc_pkg::PTR_W-1:0] rd_ptr, nx_wa, nx_wd, pv_wa, pv_wd, dt_wa;
    logic [dllc_pkg::PTR_W-1:0] head_in, tail_in, cur_in, free_in, n_in, t_in, u_in;

    always_comb begin
        rd_ptr  = pick(i_cmd.rd_addr, r_head, r_tail, r_cur, r_n, r_t, r_u, r_free,
                       rd_next, rd_prev, r_bump);
        nx_wa   = pick(i_cmd.nx_addr, r_head, r_tail, r_cur, r_n, r_t, r_u, r_free,
                       rd_next, rd_prev, r_bump);
        nx_wd   = pick(i_cmd.nx_data, r_head, r_tail, r_cur, r_n, r_t, r_u, r_free,
                       rd_next, rd_prev, r_bump);
        pv_wa   = pick(i_cmd.pv_addr, r_head, r_tail, r_cur, r_n, r_t, r_u, r_free,
                       rd_next, rd_prev, r_bump);
        pv_wd   = pick(i_cmd.pv_data, r_head, r_tail, r_cur, r_n, r_t, r_u, r_free,
                       rd_next, rd_prev, r_bump);
        dt_wa   = pick(i_cmd.dt_addr, r_head, r_tail, r_cur, r_n, r_t, r_u, r_free,
                       rd_next, rd_prev, r_bump);
        head_in = pick(i_cmd.head_src, r_head, r_tail, r_cur, r_n, r_t, r_u, r_free,
                       rd_next, rd_prev, r_bump);
        tail_in = pick(i_cmd.tail_src, r_head, r_tail, r_cur, r_n, r_t, r_u, r_free,
                       rd_next, rd_prev, r_bump);
        cur_in  = pick(i_cmd.cur_src, r_head, r_tail, r_cur, r_n, r_t, r_u, r_free,
                       rd_next, rd_prev, r_bump);
        free_in = pick(i_cmd.free_src, r_head, r_tail, r_cur, r_n, r_t, r_u, r_free,
                       rd_next, rd_prev, r_bump);
        n_in    = pick(i_cmd.n_src, r_head, r_tail, r_cur, r_n, r_t, r_u, r_free,
                       rd_next, rd_prev, r_bump);
        t_in    = pick(i_cmd.t_src, r_head, r_tail, r_cur, r_n, r_t, r_u, r_free,
                       rd_next, rd_prev, r_bump);
        u_in    = pick(i_cmd.u_src, r_head, r_tail, r_cur, r_n, r_t, r_u, r_free,
                       rd_next, rd_prev, r_bump);
    end

    dllc_ram #(.WIDTH(dllc_pkg::PTR_W), .DEPTH(dllc_pkg::POOL_NODES)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.nx_we),
        .i_waddr (nx_wa[dllc_pkg::ADDR_W-1:0]),
        .i_wdata (nx_wd),
        .i_re    (i_cmd.rd_en),
        .i_raddr (rd_ptr[dllc_pkg::ADDR_W-1:0]),
        .o_rdata (rd_next)
    );

    dllc_ram #(.WIDTH(dllc_pkg::PTR_W), .DEPTH(dllc_pkg::POOL_NODES)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.pv_we),
        .i_waddr (pv_wa[dllc_pkg::ADDR_W-1:0]),
        .i_wdata (pv_wd),
        .i_re    (i_cmd.rd_en),
        .i_raddr (rd_ptr[dllc_pkg::ADDR_W-1:0]),
        .o_rdata (rd_prev)
    );

    dllc_ram #(.WIDTH(dllc_pkg::DATA_W), .DEPTH(dllc_pkg::POOL_NODES)) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.dt_we),
        .i_waddr (dt_wa[dllc_pkg::ADDR_W-1:0]),
        .i_wdata (r_value),
        .i_re    (i_cmd.rd_en),
        .i_raddr (rd_ptr[dllc_pkg::ADDR_W-1:0]),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_head <= dllc_pkg::NIL;
            r_tail <= dllc_pkg::NIL;
            r_cur  <= dllc_pkg::NIL;
            r_free <= dllc_pkg::NIL;
            r_bump <= '0;
        end else begin
            if (i_cmd.ld_head)  r_head <= head_in;
            if (i_cmd.ld_tail)  r_tail <= tail_in;
            if (i_cmd.ld_cur)   r_cur  <= cur_in;
            if (i_cmd.ld_free)  r_free <= free_in;
            if (i_cmd.bump_inc) r_bump <= r_bump + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err <= 1'b0;
        end else if (i_cmd.ld_in) begin
            r_err <= 1'b0;
        end else if (i_cmd.err_set) begin
            r_err <= 1'b1;
        end
    end

    // active value goes straight from the cursor read into the output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_in) r_value <= i_value;
        if (i_cmd.ld_n)  r_n <= n_in;
        if (i_cmd.ld_t)  r_t <= t_in;
        if (i_cmd.ld_u)  r_u <= u_in;
        if (i_cmd.cap_first) r_fv <= (r_head == dllc_pkg::NIL) ? '0 : rd_data;
        if (i_cmd.cap_last)  r_lv <= (r_tail == dllc_pkg::NIL) ? '0 : rd_data;
        if (i_cmd.out_ld) begin
            r_o_err  <= r_err;
            r_o_fv   <= r_fv;
            r_o_lv   <= r_lv;
            r_o_av   <= (r_cur == dllc_pkg::NIL) ? '0 : rd_data;
            r_o_fvld <= (r_head != dllc_pkg::NIL);
            r_o_lvld <= (r_tail != dllc_pkg::NIL);
            r_o_avld <= (r_cur != dllc_pkg::NIL);
        end
    end

    always_comb begin
        o_stat.head_nil    = (r_head == dllc_pkg::NIL);
        o_stat.tail_nil    = (r_tail == dllc_pkg::NIL);
        o_stat.cur_nil     = (r_cur == dllc_pkg::NIL);
        o_stat.free_nil    = (r_free == dllc_pkg::NIL);
        o_stat.bump_full   = (r_bump == dllc_pkg::NIL);
        o_stat.cur_is_head = (r_cur == r_head);
        o_stat.cur_is_tail = (r_cur == r_tail);
        o_stat.cur_is_n    = (r_cur == r_n);
        o_stat.rdn_nil     = (rd_next == dllc_pkg::NIL);
        o_stat.rdp_nil     = (rd_prev == dllc_pkg::NIL);
        o_stat.u_nil       = (r_u == dllc_pkg::NIL);
    end

    assign o_status       = r_o_err;
    assign o_first_value  = $signed(r_o_fv);
    assign o_first_valid  = r_o_fvld;
    assign o_last_value   = $signed(r_o_lv);
    assign o_last_valid   = r_o_lvld;
    assign o_active_value = $signed(r_o_av);
    assign o_active_valid = r_o_avld;
endmodule

FILE: src/doubly_linked_list_with_cursor.sv
// Doubly linked list of signed 32-bit values in a pool of 64 nodes, with a cursor.
// i_cmd carries one command (op, value) per transfer; o_res returns exactly one
// result per command: pool-full status, then head, tail and cursor values with
// their valid flags (value reads 0 when its flag is low).
// Commands run one at a time through a sequencer around three node memories
// (data, next link, prev link), each with one write port and a registered read.
// i_cmd.ready rises in the same cycle the result turns valid, so a new
// command is taken only once the previous one has run to its end.
// A stalled receiver holds the result in the output register; the next command
// is still taken, but its last state (S_FIN) waits until the held result drains.
// Reset (i_rst_n low, synchronous) empties the list and the node pool;
// clear does the same. No clearing pass is needed.
module doubly_linked_list_with_cursor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dllc_cmd_if.sink    i_cmd,
    dllc_res_if.source  o_res
);
    dllc_pkg::t_cmd  s_cmd;
    dllc_pkg::t_stat s_stat;

    dllc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .o_in_ready  (i_cmd.ready),
        .i_op        (i_cmd.op),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_cmd       (s_cmd),
        .i_stat      (s_stat)
    );

    dllc_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (s_cmd),
        .o_stat         (s_stat),
        .i_value        (i_cmd.value),
        .o_status       (o_res.status),
        .o_first_value  (o_res.first_value),
        .o_first_valid  (o_res.first_valid),
        .o_last_value   (o_res.last_value),
        .o_last_valid   (o_res.last_valid),
        .o_active_value (o_res.active_value),
        .o_active_valid (o_res.active_valid)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |=> !i_cmd.ready)
        else $error("command taken while previous one still in progress");

    a_ends_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_stat.head_nil == s_stat.tail_nil)
        else $error("head and tail disagree on empty list");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.clear |=> (s_stat.head_nil && s_stat.cur_nil && s_stat.free_nil))
        else $error("clear left list state behind");

    a_result_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.first_valid == o_res.last_valid))
        else $error("result head and tail flags differ");
endmodule

FILE: bench/tb_doubly_linked_list_with_cursor.sv
module tb_doubly_linked_list_with_cursor;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES = dllc_pkg::POOL_NODES;

    typedef struct packed {
        logic               status;
        logic signed [31:0] first_value;
        logic               first_valid;
        logic signed [31:0] last_value;
        logic               last_valid;
        logic signed [31:0] active_value;
        logic               active_valid;
    } t_view;

    // Scoreboard: shadow list plus queue of expected views
    class list_scoreboard;
        logic [31:0] data [NODES];
        int          nxt  [NODES];
        int          prv  [NODES];
        int          head, tail, cur, free_top, bump;
        t_view       pending[$];
        int          errors;
        int          length;

        function void wipe();
            head = NODES; tail = NODES; cur = NODES;
            free_top = NODES; bump = 0; length = 0;
        endfunction

        function int grab(logic [31:0] v);
            int n;
            if (free_top != NODES) begin
                n = free_top;
                free_top = nxt[n];
            end else if (bump < NODES) begin
                n = bump;
                bump++;
            end else begin
                return NODES;
            end
            data[n] = v;
            length++;
            return n;
        endfunction

        function void drop(int n);
            nxt[n] = free_top;
            free_top = n;
            length--;
        endfunction

        function void note_command(dllc_pkg::t_op op, logic [31:0] v);
            t_view r;
            int n, t, u;
            logic st;
            st = 1'b0;
            case (op)
                dllc_pkg::OP_CLEAR: wipe();
                dllc_pkg::OP_INS_FIRST, dllc_pkg::OP_INS_LAST: begin
                    n = grab(v);
                    if (n == NODES) st = 1'b1;
                    else if (head == NODES) begin
                        nxt[n] = NODES; prv[n] = NODES; head = n; tail = n;
                    end else if (op == dllc_pkg::OP_INS_FIRST) begin
                        prv[n] = NODES; nxt[n] = head; prv[head] = n; head = n;
                    end else begin
                        nxt[n] = NODES; prv[n] = tail; nxt[tail] = n; tail = n;
                    end
                end
                dllc_pkg::OP_CUR_FIRST: cur = head;
                dllc_pkg::OP_CUR_LAST:  cur = tail;
                dllc_pkg::OP_DEL_FIRST: if (head != NODES) begin
                    n = head;
                    if (cur == n) cur = NODES;
                    head = nxt[n];
                    if (head == NODES) tail = NODES;
                    else prv[head] = NODES;
                    drop(n);
                end
                dllc_pkg::OP_DEL_LAST: if (tail != NODES) begin
                    n = tail;
                    if (cur == n) cur = NODES;
                    tail = prv[n];
                    if (tail == NODES) head = NODES;
                    else nxt[tail] = NODES;
                    drop(n);
                end
                dllc_pkg::OP_DEL_AFTER: if (cur != NODES && cur != tail) begin
                    t = nxt[cur]; u = nxt[t];
                    nxt[cur] = u;
                    if (u == NODES) tail = cur; else prv[u] = cur;
                    drop(t);
                end
                dllc_pkg::OP_DEL_BEFORE: if (cur != NODES && cur != head) begin
                    t = prv[cur]; u = prv[t];
                    prv[cur] = u;
                    if (u == NODES) head = cur; else nxt[u] = cur;
                    drop(t);
                end
                dllc_pkg::OP_INS_AFTER: if (cur != NODES) begin
                    n = grab(v);
                    if (n == NODES) st = 1'b1;
                    else begin
                        u = nxt[cur]; nxt[n] = u; prv[n] = cur; nxt[cur] = n;
                        if (u == NODES) tail = n; else prv[u] = n;
                    end
                end
                dllc_pkg::OP_INS_BEFORE: if (cur != NODES) begin
                    n = grab(v);
                    if (n == NODES) st = 1'b1;
                    else begin
                        u = prv[cur]; prv[n] = u; nxt[n] = cur; prv[cur] = n;
                        if (u == NODES) head = n; else nxt[u] = n;
                    end
                end
                dllc_pkg::OP_WRITE: if (cur != NODES) data[cur] = v;
                dllc_pkg::OP_NEXT: if (cur != NODES) cur = (cur == tail) ? NODES : nxt[cur];
                dllc_pkg::OP_PREV: if (cur != NODES) cur = (cur == head) ? NODES : prv[cur];
                default: ;
            endcase
            r.status       = st;
            r.first_valid  = head != NODES;
            r.first_value  = r.first_valid ? data[head] : '0;
            r.last_valid   = tail != NODES;
            r.last_value   = r.last_valid ? data[tail] : '0;
            r.active_valid = cur != NODES;
            r.active_value = r.active_valid ? data[cur] : '0;
            pending.push_back(r);
        endfunction

        function void check_result(t_view a);
            t_view e;
            if (pending.size() == 0) begin
                $error("result with nothing expected");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.status !== e.status) begin
                $error("status exp %0d got %0d", e.status, a.status); errors++;
            end
            if (a.first_value !== e.first_value) begin
                $error("first_value exp %0d got %0d", e.first_value, a.first_value); errors++;
            end
            if (a.first_valid !== e.first_valid) begin
                $error("first_valid exp %0d got %0d", e.first_valid, a.first_valid); errors++;
            end
            if (a.last_value !== e.last_value) begin
                $error("last_value exp %0d got %0d", e.last_value, a.last_value); errors++;
            end
            if (a.last_valid !== e.last_valid) begin
                $error("last_valid exp %0d got %0d", e.last_valid, a.last_valid); errors++;
            end
            if (a.active_value !== e.active_value) begin
                $error("active_value exp %0d got %0d", e.active_value, a.active_value); errors++;
            end
            if (a.active_valid !== e.active_valid) begin
                $error("active_valid exp %0d got %0d", e.active_valid, a.active_valid); errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    dllc_cmd_if cmd_bus();
    dllc_res_if res_bus();

    doubly_linked_list_with_cursor u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus.sink),
        .o_res   (res_bus.source)
    );

    always #5 i_clk = ~i_clk;

    list_scoreboard list_sb = new();
    int  send_idle_pct  = 0;
    int  stall_pct      = 0;
    int  idle_cycles    = 0;
    bit  stim_done      = 0;

    initial begin
        cmd_bus.valid = 1'b0;
        cmd_bus.op    = '0;
        cmd_bus.value = '0;
        res_bus.ready = 1'b0;
    end

    // receiver: random stall, check on rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && res_bus.valid && res_bus.ready)
            list_sb.check_result({res_bus.status, res_bus.first_value, res_bus.first_valid,
                                  res_bus.last_value, res_bus.last_valid,
                                  res_bus.active_value, res_bus.active_valid});
    end
    always @(negedge i_clk)
        res_bus.ready <= ($urandom_range(99) >= stall_pct);

    // watchdog on cycles with no transfer at all
    always @(posedge i_clk) begin
        if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // valid stays high into the next command unless the sender idles
    task automatic send_cmd(dllc_pkg::t_op op, logic [31:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_bus.valid <= 1'b1;
        cmd_bus.op    <= op;
        cmd_bus.value <= v;
        @(posedge i_clk);
        while (!cmd_bus.ready) @(posedge i_clk);
        list_sb.note_command(op, v);
        @(negedge i_clk);
    endtask

    task automatic drain();
        cmd_bus.valid <= 1'b0;
        while (list_sb.pending.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'h0;
            default: return $urandom();
        endcase
    endfunction

    // biased toward a populated list; clears are rare so the pool fills
    function automatic dllc_pkg::t_op rand_op();
        int k;
        k = $urandom_range(99);
        if (k < 1) return dllc_pkg::OP_CLEAR;
        if (k < 16) return dllc_pkg::OP_INS_LAST;
        if (k < 28) return dllc_pkg::OP_INS_FIRST;
        if (k < 34) return dllc_pkg::OP_CUR_FIRST;
        if (k < 39) return dllc_pkg::OP_CUR_LAST;
        if (k < 43) return dllc_pkg::OP_DEL_FIRST;
        if (k < 47) return dllc_pkg::OP_DEL_LAST;
        if (k < 52) return dllc_pkg::OP_DEL_AFTER;
        if (k < 57) return dllc_pkg::OP_DEL_BEFORE;
        if (k < 67) return dllc_pkg::OP_INS_AFTER;
        if (k < 76) return dllc_pkg::OP_INS_BEFORE;
        if (k < 81) return dllc_pkg::OP_WRITE;
        if (k < 89) return dllc_pkg::OP_NEXT;
        if (k < 97) return dllc_pkg::OP_PREV;
        if (k < 99) return dllc_pkg::OP_QUERY;
        return dllc_pkg::t_op'(4'hf);
    endfunction

    initial begin
        int i;
        int phase;
        list_sb.wipe();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty-list corners, single element, ends, op 15
        send_cmd(dllc_pkg::OP_DEL_FIRST, 0);
        send_cmd(dllc_pkg::OP_DEL_LAST, 0);
        send_cmd(dllc_pkg::OP_NEXT, 0);
        send_cmd(dllc_pkg::OP_INS_AFTER, 5);
        send_cmd(dllc_pkg::OP_WRITE, 9);
        send_cmd(dllc_pkg::OP_INS_FIRST, 32'h8000_0000);
        send_cmd(dllc_pkg::OP_CUR_FIRST, 0);
        send_cmd(dllc_pkg::OP_DEL_FIRST, 0);
        send_cmd(dllc_pkg::OP_INS_LAST, 32'h7fff_ffff);
        send_cmd(dllc_pkg::OP_INS_FIRST, 32'hffff_ffff);
        send_cmd(dllc_pkg::OP_CUR_LAST, 0);
        send_cmd(dllc_pkg::OP_DEL_AFTER, 0);
        send_cmd(dllc_pkg::OP_INS_BEFORE, 32'h5555_5555);
        send_cmd(dllc_pkg::OP_INS_AFTER, 32'haaaa_aaaa);
        send_cmd(dllc_pkg::OP_PREV, 0);
        send_cmd(dllc_pkg::OP_DEL_BEFORE, 0);
        send_cmd(dllc_pkg::OP_WRITE, 32'h1234_5678);
        send_cmd(dllc_pkg::OP_CUR_FIRST, 0);
        send_cmd(dllc_pkg::OP_DEL_BEFORE, 0);
        send_cmd(dllc_pkg::OP_PREV, 0);
        send_cmd(dllc_pkg::OP_QUERY, 0);
        send_cmd(dllc_pkg::t_op'(4'hf), 0);
        send_cmd(dllc_pkg::OP_DEL_LAST, 0);
        // fill the pool past its end to hit the full status
        for (i = 0; i < NODES + 2; i++) send_cmd(dllc_pkg::OP_INS_LAST, $urandom());
        send_cmd(dllc_pkg::OP_CUR_LAST, 0);
        send_cmd(dllc_pkg::OP_INS_BEFORE, 1);
        drain();
        send_cmd(dllc_pkg::OP_CLEAR, 0);

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 59; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 59; end
                default: begin send_idle_pct = 12; stall_pct = 12; end
            endcase
            for (i = 0; i < 300; i++) begin
                if (i == 150) drain();
                send_cmd(rand_op(), rand_value());
            end
        end

        drain();
        repeat (30) @(negedge i_clk);
        if (list_sb.errors == 0 && list_sb.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
